### hw/rtl/point_rotate_and_project_top_macros.svh
// Assertion macros for the point rotate-and-project block.
// Included by the checker module; no other dependencies.
`ifndef POINT_ROTATE_AND_PROJECT_TOP_MACROS_SVH
`define POINT_ROTATE_AND_PROJECT_TOP_MACROS_SVH

// Plain clocked assertion, active during reset too.
`define PRP_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is ignored while the reset is applied.
`define PRP_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### hw/rtl/prp_pkg.sv
// Shared types, constants and fixed-point helpers of the rotate-and-project block.
// No dependencies; used by every RTL module of the block.
package prp_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Internal Q16.16 values are saturated to +-2^48 and need 50 bits.
  localparam int QW      = 50;
  localparam int TW      = QW - 16;
  localparam int MUL_LAT = 3;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [127:0]  wide_t;
  typedef logic signed [TW-1:0] tr_t;
  typedef logic signed [TW:0]   sx_t;

  localparam wide_t LIM_POS = wide_t'(64'sd1 <<< 48);
  localparam wide_t LIM_NEG = -LIM_POS;

  localparam sx_t S32_MAX = sx_t'(64'sd2147483647);
  localparam sx_t S32_MIN = sx_t'(-64'sd2147483648);

  // Projection constants, Q1.14 unless named otherwise.
  localparam logic signed [15:0] C30     = 16'sd14189;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam int                 S30     = 8192;
  localparam int                 S30_Q16 = S30 * 4;
  localparam logic signed [16:0] ONE_Q8  = 17'sd256;

  // Configuration port.
  localparam int CFG_W  = 17;
  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MODE       = 3'd0,
    CFG_COS        = 3'd1,
    CFG_SIN        = 3'd2,
    CFG_ZSCALE     = 3'd3,
    CFG_VSCALE     = 3'd4,
    CFG_WIDTH      = 3'd5,
    CFG_OFFSET_X   = 3'd6,
    CFG_VORIGIN    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_ISO  = 2'd0,
    MODE_ZSUM = 2'd1,
    MODE_DIAG = 2'd2
  } mode_t;

  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
    logic signed [15:0] z_scale;
    logic        [15:0] view_scale;
    logic        [12:0] image_width;
    logic signed [15:0] offset_x;
    logic signed [16:0] vertical_origin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:            MODE_ISO,
    rot_cos:         16'sd16384,
    rot_sin:         16'sd0,
    z_scale:         16'sd256,
    view_scale:      16'd256,
    image_width:     13'd1024,
    offset_x:        16'sd0,
    vertical_origin: 17'sd768
  };

  // Saturate to +-2^48.
  function automatic q_t clamp_q(input wide_t v);
    if (v > LIM_POS) begin
      return q_t'(LIM_POS[QW-1:0]);
    end
    if (v < LIM_NEG) begin
      return $signed(LIM_NEG[QW-1:0]);
    end
    return $signed(v[QW-1:0]);
  endfunction

  // Drop 16 fraction bits, rounding toward zero.
  function automatic tr_t trunc16(input q_t v);
    logic [QW:0] t;
    t = {v[QW-1], v} + {{(QW-15){1'b0}}, {16{v[QW-1]}}};
    return $signed(t[QW-1:16]);
  endfunction

  // Saturate to signed 32 bits.
  function automatic logic signed [31:0] sat32(input sx_t v);
    if (v > S32_MAX) begin
      return 32'sh7fffffff;
    end
    if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return $signed(v[31:0]);
  endfunction

endpackage

### hw/rtl/prp_cfg.sv
// Configuration register file of the rotate-and-project block.
// Depends on prp_pkg for the register struct, indexes and reset values.
module prp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [prp_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [prp_pkg::CFG_W-1:0]   cfg_wdata,
  output prp_pkg::cfg_t               cfg
);

  prp_pkg::cfg_t cfg_r;
  prp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        prp_pkg::CFG_MODE:     cfg_nxt.mode            = cfg_wdata[1:0];
        prp_pkg::CFG_COS:      cfg_nxt.rot_cos         = $signed(cfg_wdata[15:0]);
        prp_pkg::CFG_SIN:      cfg_nxt.rot_sin         = $signed(cfg_wdata[15:0]);
        prp_pkg::CFG_ZSCALE:   cfg_nxt.z_scale         = $signed(cfg_wdata[15:0]);
        prp_pkg::CFG_VSCALE:   cfg_nxt.view_scale      = cfg_wdata[15:0];
        prp_pkg::CFG_WIDTH:    cfg_nxt.image_width     = cfg_wdata[12:0];
        prp_pkg::CFG_OFFSET_X: cfg_nxt.offset_x        = $signed(cfg_wdata[15:0]);
        prp_pkg::CFG_VORIGIN:  cfg_nxt.vertical_origin = $signed(cfg_wdata[16:0]);
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= prp_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/prp_mulq.sv
// Three-stage signed multiplier with floor shift and +-2^48 saturation.
// Depends on prp_pkg for the Q16.16 type and the clamp helper.
module prp_mulq #(
  parameter int AW = 50,
  parameter int BW = 16,
  parameter int SH = 14
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output prp_pkg::q_t          q
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic        [AL-1:0] al;
  logic signed [AH-1:0] ah;
  logic        [BL-1:0] bl;
  logic signed [BH-1:0] bh;

  logic        [AL+BL-1:0] ll_r, ll_nxt;
  logic signed [AL+BH:0]   lh_r, lh_nxt;
  logic signed [AH+BL:0]   hl_r, hl_nxt;
  logic signed [AH+BH-1:0] hh_r, hh_nxt;
  logic signed [PW-1:0]    t0_r, t0_nxt, t1_r, t1_nxt, p;
  prp_pkg::q_t             q_r, q_nxt;

  assign al = a[AL-1:0];
  assign ah = $signed(a[AW-1:AL]);
  assign bl = b[BL-1:0];
  assign bh = $signed(b[BW-1:BL]);

  always_comb begin
    // partial products on half-width operands
    ll_nxt = al * bl;
    lh_nxt = $signed({1'b0, al}) * bh;
    hl_nxt = ah * $signed({1'b0, bl});
    hh_nxt = ah * bh;
    // pair them up
    t0_nxt = PW'($signed({1'b0, ll_r})) + (PW'(lh_r) <<< BL);
    t1_nxt = (PW'(hh_r) <<< (AL + BL)) + (PW'(hl_r) <<< AL);
    // final sum, floor shift, saturate
    p      = t0_r + t1_r;
    q_nxt  = prp_pkg::clamp_q(prp_pkg::wide_t'(p >>> SH));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
      q_r  <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

### hw/rtl/prp_rot.sv
// Rotation about the y axis and the difference/sum stage, four register stages.
// Depends on prp_pkg for the configuration struct and Q16.16 helpers.
module prp_rot #(
  parameter int COORD_BITS = prp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ce,
  input  prp_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  output logic                         out_valid,
  output prp_pkg::q_t                  dif,
  output prp_pkg::q_t                  sum,
  output prp_pkg::q_t                  ntz
);

  localparam int W  = COORD_BITS;
  localparam int RS = 4;
  localparam int SW = W + 33;
  localparam int EW = (SW > prp_pkg::QW + 6) ? SW : prp_pkg::QW + 6;

  logic [RS-1:0] vld_r;

  // stage 1
  logic signed [W+15:0] xc1_r, xs1_r;
  logic signed [31:0]   gs1_r, gc1_r;
  logic signed [W-1:0]  y1_r, z1_r;
  // stage 2
  logic signed [W+15:0] xc2_r, xs2_r;
  logic signed [W+31:0] zs2_r, zc2_r;
  logic signed [W-1:0]  y2_r;
  // stage 3
  logic signed [EW-1:0] ax, az;
  prp_pkg::q_t          tx_r, tz_r, tx_nxt, tz_nxt;
  logic signed [W-1:0]  y3_r;
  // stage 4
  prp_pkg::q_t          ty;
  prp_pkg::q_t          dif_r, sum_r, ntz_r, dif_nxt, sum_nxt, ntz_nxt;

  always_comb begin
    ax      = (EW'(xc2_r) <<< 8) + EW'(zs2_r);
    az      = EW'(zc2_r) - (EW'(xs2_r) <<< 8);
    tx_nxt  = prp_pkg::clamp_q(prp_pkg::wide_t'(ax >>> 6));
    tz_nxt  = prp_pkg::clamp_q(prp_pkg::wide_t'(az >>> 6));
    ty      = prp_pkg::q_t'(y3_r) <<< 16;
    dif_nxt = prp_pkg::clamp_q(prp_pkg::wide_t'(tx_r) - prp_pkg::wide_t'(ty));
    sum_nxt = prp_pkg::clamp_q(prp_pkg::wide_t'(tx_r) + prp_pkg::wide_t'(ty));
    ntz_nxt = -tz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[RS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xc1_r <= in_x * $signed(cfg.rot_cos);
      xs1_r <= in_x * $signed(cfg.rot_sin);
      gs1_r <= $signed(cfg.z_scale) * $signed(cfg.rot_sin);
      gc1_r <= $signed(cfg.z_scale) * $signed(cfg.rot_cos);
      y1_r  <= in_y;
      z1_r  <= in_z;

      xc2_r <= xc1_r;
      xs2_r <= xs1_r;
      zs2_r <= z1_r * gs1_r;
      zc2_r <= z1_r * gc1_r;
      y2_r  <= y1_r;

      tx_r  <= tx_nxt;
      tz_r  <= tz_nxt;
      y3_r  <= y2_r;

      dif_r <= dif_nxt;
      sum_r <= sum_nxt;
      ntz_r <= ntz_nxt;
    end
  end

  assign out_valid = vld_r[RS-1];
  assign dif       = dif_r;
  assign sum       = sum_r;
  assign ntz       = ntz_r;

endmodule

### hw/rtl/prp_proj.sv
// Projection datapath: two multiplier rounds, centering, offsets, truncation, saturation.
// Depends on prp_pkg and prp_mulq.
module prp_proj (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  prp_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  prp_pkg::q_t        dif,
  input  prp_pkg::q_t        sum,
  input  prp_pkg::q_t        ntz,
  output logic               out_valid,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y
);

  localparam int ML = prp_pkg::MUL_LAT;
  localparam int PS = 2 * ML + 5;

  logic is_iso, is_zsum, diag;
  logic signed [16:0] vs17;
  prp_pkg::wide_t     half_w, half_v, ox16;

  logic [PS-1:0] vld_r;
  prp_pkg::q_t   ntz_d_r [ML];

  logic signed [15:0] mx1_b;
  prp_pkg::q_t        my1_a, my1_b, mx1_q, my1_q;
  prp_pkg::q_t        cx_r, cy_r, cy_nxt;
  logic signed [16:0] my2_b;
  prp_pkg::q_t        mx2_q, my2_q;
  prp_pkg::q_t        ex_r, ey_r, ex_nxt, ey_nxt;
  prp_pkg::q_t        fx_r, fy_r, fx_nxt;
  prp_pkg::tr_t       gx_r, gy_r;
  prp_pkg::sx_t       ox_h;
  logic signed [31:0] sx_r, sy_r;

  assign is_iso  = (cfg.mode == prp_pkg::MODE_ISO);
  assign is_zsum = (cfg.mode == prp_pkg::MODE_ZSUM);
  assign diag    = !is_iso && !is_zsum;
  assign vs17    = $signed({1'b0, cfg.view_scale});
  assign half_w  = prp_pkg::wide_t'($signed({1'b0, cfg.image_width, 15'd0}));
  assign half_v  = prp_pkg::wide_t'($signed({cfg.vertical_origin, 15'd0}));
  assign ox16    = prp_pkg::wide_t'($signed({cfg.offset_x, 16'd0}));

  // first round: x by the 30-degree cosine (or unity), y by sine, sum or scale
  assign mx1_b = is_iso ? prp_pkg::C30 : prp_pkg::ONE_Q14;
  assign my1_a = is_zsum ? ntz : sum;
  assign my1_b = is_iso  ? prp_pkg::q_t'(prp_pkg::S30_Q16) :
                 is_zsum ? sum :
                           prp_pkg::q_t'($signed({1'b0, cfg.view_scale, 8'd0}));

  prp_mulq #(.AW(prp_pkg::QW), .BW(16), .SH(14)) u_mx1 (
    .clk (clk), .ce (ce), .a (dif), .b (mx1_b), .q (mx1_q)
  );

  prp_mulq #(.AW(prp_pkg::QW), .BW(prp_pkg::QW), .SH(16)) u_my1 (
    .clk (clk), .ce (ce), .a (my1_a), .b (my1_b), .q (my1_q)
  );

  // second round: view scale (diagonal mode leaves y as is)
  assign my2_b = diag ? prp_pkg::ONE_Q8 : vs17;

  prp_mulq #(.AW(prp_pkg::QW), .BW(17), .SH(8)) u_mx2 (
    .clk (clk), .ce (ce), .a (cx_r), .b (vs17), .q (mx2_q)
  );

  prp_mulq #(.AW(prp_pkg::QW), .BW(17), .SH(8)) u_my2 (
    .clk (clk), .ce (ce), .a (cy_r), .b (my2_b), .q (my2_q)
  );

  always_comb begin
    cy_nxt = is_zsum ? my1_q :
             prp_pkg::clamp_q(prp_pkg::wide_t'(ntz_d_r[ML-1]) + prp_pkg::wide_t'(my1_q));
    ex_nxt = prp_pkg::clamp_q(prp_pkg::wide_t'(mx2_q) + half_w);
    ey_nxt = prp_pkg::clamp_q(prp_pkg::wide_t'(my2_q) + half_v);
    fx_nxt = diag ? prp_pkg::clamp_q(prp_pkg::wide_t'(ex_r) + ox16) : ex_r;
    ox_h   = diag ? '0 : prp_pkg::sx_t'($signed(cfg.offset_x));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[PS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ntz_d_r[0] <= ntz;
      for (int i = 1; i < ML; i++) begin
        ntz_d_r[i] <= ntz_d_r[i-1];
      end
      cx_r <= mx1_q;
      cy_r <= cy_nxt;
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
      fx_r <= fx_nxt;
      fy_r <= ey_r;
      gx_r <= prp_pkg::trunc16(fx_r);
      gy_r <= prp_pkg::trunc16(fy_r);
      sx_r <= prp_pkg::sat32(prp_pkg::sx_t'(gx_r) + ox_h);
      sy_r <= prp_pkg::sat32(prp_pkg::sx_t'(gy_r));
    end
  end

  assign out_valid = vld_r[PS-1];
  assign screen_x  = sx_r;
  assign screen_y  = sy_r;

endmodule

### hw/rtl/point_rotate_and_project_top.sv
// Usage
//   Maps 3D grid points to screen coordinates, one request per unstalled clock.
//   Input channel in_*: in_valid with in_pos_x/y/z (COORD_BITS signed each).
//   A request is taken at a rising edge with in_valid high and in_stall low.
//   Output channel out_*: out_valid with out_screen_x/y (32-bit signed,
//   saturated); taken at an edge with out_valid high and out_stall low.
//   Configuration: cfg_we, cfg_addr (register index), cfg_wdata; one write per
//   edge, no wait. Write only while no request is in flight.
//   Throughput: one request per cycle while in_stall is low, from a fully
//   pipelined datapath (four rotation stages, two rounds of three-stage
//   split multipliers, then centering, truncation and saturation stages).
//   Reset (rst_n low, synchronous): empties the pipeline and restores the
//   default registers (isometric, no rotation, unity gains, width 1024).
//   Stall: a result held on a stalled output is backed by one skid entry;
//   the pipeline keeps going until that entry fills, then freezes and raises
//   in_stall. No request is dropped or repeated.
module point_rotate_and_project_top #(
  parameter int COORD_BITS = prp_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      in_pos_x,
  input  logic signed [COORD_BITS-1:0]      in_pos_y,
  input  logic signed [COORD_BITS-1:0]      in_pos_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_screen_x,
  output logic signed [31:0]                out_screen_y,
  input  logic                              cfg_we,
  input  logic [prp_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [prp_pkg::CFG_W-1:0]         cfg_wdata
);

  prp_pkg::cfg_t cfg;
  logic          ce;

  logic          rot_valid;
  prp_pkg::q_t   rot_dif, rot_sum, rot_ntz;

  logic               prj_valid;
  logic signed [31:0] prj_x, prj_y;

  logic               out_valid_r, out_valid_nxt;
  logic               sk_valid_r, sk_valid_nxt;
  logic signed [31:0] out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic signed [31:0] sk_x_r, sk_y_r;
  logic               take, load_out, load_sk;

  // The whole pipeline advances unless the skid entry is occupied.
  assign ce       = !sk_valid_r;
  assign in_stall = sk_valid_r;

  prp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  prp_rot #(.COORD_BITS(COORD_BITS)) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_x      (in_pos_x),
    .in_y      (in_pos_y),
    .in_z      (in_pos_z),
    .out_valid (rot_valid),
    .dif       (rot_dif),
    .sum       (rot_sum),
    .ntz       (rot_ntz)
  );

  prp_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .cfg       (cfg),
    .in_valid  (rot_valid),
    .dif       (rot_dif),
    .sum       (rot_sum),
    .ntz       (rot_ntz),
    .out_valid (prj_valid),
    .screen_x  (prj_x),
    .screen_y  (prj_y)
  );

  // Output register plus one skid entry.
  always_comb begin
    take          = out_valid_r && !out_stall;
    out_valid_nxt = out_valid_r;
    sk_valid_nxt  = sk_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    load_out      = 1'b0;
    load_sk       = 1'b0;
    if (ce && prj_valid) begin
      if (!out_valid_r || take) begin
        // land the new result directly on the output
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
        out_x_nxt     = prj_x;
        out_y_nxt     = prj_y;
      end else begin
        // output is held: park the result in the skid entry
        load_sk      = 1'b1;
        sk_valid_nxt = 1'b1;
      end
    end else if (take) begin
      if (sk_valid_r) begin
        // drain the skid entry onto the output
        load_out     = 1'b1;
        out_x_nxt    = sk_x_r;
        out_y_nxt    = sk_y_r;
        sk_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
    end
    if (load_sk) begin
      sk_x_r <= prj_x;
      sk_y_r <= prj_y;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = out_x_r;
  assign out_screen_y = out_y_r;

endmodule

### hw/rtl/prp_checker.sv
// Port-level checker for the rotate-and-project top level, bound to it below.
// Depends on point_rotate_and_project_top_macros.svh for the assertion macros.
`include "point_rotate_and_project_top_macros.svh"

module prp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_screen_x,
  input logic signed [31:0] out_screen_y
);

  logic        held;
  logic [63:0] out_xy;

  assign held   = out_valid && out_stall;
  assign out_xy = {out_screen_x, out_screen_y};

  // reset empties the output side and the skid entry
  `PRP_ASSERT(a_reset_clear, clk, !rst_n |=> !out_valid && !in_stall, "reset left results")
  // a held result stays put
  `PRP_ASSERT_RUN(a_hold, clk, rst_n, held |=> out_valid && $stable(out_xy), "held result changed")
  // input backpressure only with a full output that was stalled last cycle
  `PRP_ASSERT_RUN(a_stall_src, clk, rst_n, in_stall |-> out_valid && $past(out_stall), "bad stall")
  // the skid entry drains only when the output is taken
  `PRP_ASSERT_RUN(a_drain, clk, rst_n, $fell(in_stall) |-> $past(out_valid && !out_stall), "bad drain")

endmodule

bind point_rotate_and_project_top prp_checker u_prp_checker (.*);
